[sv/nnue_pkg.sv]
`timescale 1ns / 1ps

package nnue_pkg;

  typedef logic [1:0] cmd_code_t;

  localparam cmd_code_t CMD_WR_ENTRY = 2'd0;
  localparam cmd_code_t CMD_WR_GATE  = 2'd1;
  localparam cmd_code_t CMD_SET_BIT  = 2'd2;
  localparam cmd_code_t CMD_UPDATE   = 2'd3;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SENSOR_COUNT = 2'd0;
  localparam cfg_idx_t CFG_DEEP_COUNT   = 2'd1;
  localparam cfg_idx_t CFG_OUTPUT_COUNT = 2'd2;

  localparam int CFG_W = 7;

  localparam logic [CFG_W-1:0] SENSOR_COUNT_RST = 7'd8;
  localparam logic [CFG_W-1:0] DEEP_COUNT_RST   = 7'd48;
  localparam logic [CFG_W-1:0] OUTPUT_COUNT_RST = 7'd8;

  typedef struct packed {
    cmd_code_t  command;
    logic [7:0] index;
    logic [5:0] source_neuron;
    logic [7:0] first_entry;
    logic [8:0] entry_count;
    logic       bit_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] neuron_values;
    logic        bad_index;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic pass_start;
    logic clr_step;
    logic gate_rd;
    logic gate_load;
    logic ent_step;
    logic gate_fin;
    logic out_load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic gate_live;
    logic ent_done;
  } ctl_sts_t;

endpackage

[sv/nnue_ctrl.sv]
`timescale 1ns / 1ps

module nnue_ctrl import nnue_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  cmd_code_t in_command,
  output logic      in_stall,
  input  logic      out_stall,
  output logic      out_valid,
  input  ctl_sts_t  sts,
  output ctl_cmd_t  cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_GATE  = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_ENT   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_command == CMD_UPDATE) begin
            cmd.pass_start = 1'b1;
            state_nxt      = ST_GATE;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_GATE: begin
        if (sts.gate_live) begin
          cmd.gate_rd = 1'b1;
          state_nxt   = ST_LOAD;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_LOAD: begin
        cmd.gate_load = 1'b1;
        state_nxt     = ST_ENT;
      end
      ST_ENT: begin
        if (sts.ent_done) begin
          cmd.gate_fin = 1'b1;
          state_nxt    = ST_GATE;
        end else begin
          cmd.ent_step = 1'b1;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[sv/nnue_dp.sv]
`timescale 1ns / 1ps

module nnue_dp import nnue_pkg::*; #(
  parameter int MAX_NEURONS = 64,
  parameter int MAX_ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_data,
  input  logic             cfg_wr_en,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  ctl_cmd_t         cmd,
  output ctl_sts_t         sts,
  output out_item_t        out_data
);

  localparam int GW        = $clog2(MAX_NEURONS);
  localparam int AW        = $clog2(MAX_ENTRIES);
  localparam int CLR_DEPTH = (MAX_ENTRIES > MAX_NEURONS) ? MAX_ENTRIES : MAX_NEURONS;
  localparam int CW        = $clog2(CLR_DEPTH);

  logic [5:0] src_mem   [MAX_ENTRIES];
  logic [7:0] gfirst_mem[MAX_NEURONS];
  logic [8:0] glen_mem  [MAX_NEURONS];

  logic [CFG_W-1:0]       sensor_r, deep_r, output_r;
  logic [MAX_NEURONS-1:0] vbits_r, vbits_nxt;
  logic [CW-1:0]          clr_cnt_r;
  logic [6:0]             g_r;
  logic                   ent_vld_r;
  logic                   bad_r, bad_nxt;
  logic                   nand_r;
  logic [9:0]             j_r, stop_r;
  logic [5:0]             src_rd_r;
  logic [7:0]             gf_rd_r;
  logic [8:0]             gl_rd_r;
  out_item_t              out_data_r;

  logic [7:0] gates, target;
  logic [9:0] span_end, stop_nxt;
  logic       src_ok, hit;
  logic       entry_ok, gate_ok, neuron_ok;

  assign gates  = 8'(deep_r) + 8'(output_r);
  assign target = 8'(sensor_r) + 8'(g_r);

  assign sts.clr_last  = (clr_cnt_r == CW'(CLR_DEPTH - 1));
  assign sts.gate_live = (8'(g_r) < gates) && (32'(target) < MAX_NEURONS);
  assign sts.ent_done  = (j_r >= stop_r);

  // a source beyond the vector reads as zero
  assign src_ok = (32'(src_rd_r) < MAX_NEURONS);
  assign hit    = ent_vld_r && (src_ok ? !vbits_r[GW'(src_rd_r)] : 1'b1);

  assign span_end = 10'(gf_rd_r) + 10'(gl_rd_r);
  assign stop_nxt = (32'(span_end) > MAX_ENTRIES) ? 10'(MAX_ENTRIES) : span_end;

  assign entry_ok  = (32'(in_data.index) < MAX_ENTRIES);
  assign gate_ok   = (32'(in_data.index) < MAX_NEURONS);
  assign neuron_ok = gate_ok;

  always_comb begin
    vbits_nxt = vbits_r;
    bad_nxt   = bad_r;
    if (cmd.accept) begin
      unique case (in_data.command)
        CMD_WR_ENTRY: bad_nxt = !entry_ok;
        CMD_WR_GATE:  bad_nxt = !gate_ok;
        CMD_SET_BIT: begin
          bad_nxt = !neuron_ok;
          if (neuron_ok) vbits_nxt[GW'(in_data.index)] = in_data.bit_value;
        end
        CMD_UPDATE:   bad_nxt = 1'b0;
        default:      bad_nxt = 1'b0;
      endcase
    end
    if (cmd.gate_fin) vbits_nxt[GW'(target)] = nand_r | hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_r  <= SENSOR_COUNT_RST;
      deep_r    <= DEEP_COUNT_RST;
      output_r  <= OUTPUT_COUNT_RST;
      vbits_r   <= '0;
      clr_cnt_r <= '0;
      g_r       <= '0;
      ent_vld_r <= 1'b0;
      bad_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SENSOR_COUNT: sensor_r <= cfg_wdata;
          CFG_DEEP_COUNT:   deep_r   <= cfg_wdata;
          CFG_OUTPUT_COUNT: output_r <= cfg_wdata;
          default: ;
        endcase
      end
      vbits_r   <= vbits_nxt;
      bad_r     <= bad_nxt;
      ent_vld_r <= cmd.ent_step;
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + CW'(1);
      if (cmd.pass_start) begin
        g_r <= '0;
      end else if (cmd.gate_fin) begin
        g_r <= g_r + 7'd1;
      end
    end
  end

  // per-gate walk over the connection table
  always_ff @(posedge clk) begin
    if (cmd.gate_load) begin
      j_r    <= 10'(gf_rd_r);
      stop_r <= stop_nxt;
      nand_r <= 1'b0;
    end else begin
      if (cmd.ent_step) j_r <= j_r + 10'd1;
      if (hit) nand_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_data_r.neuron_values <= 64'(vbits_r);
      out_data_r.bad_index     <= bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step && (32'(clr_cnt_r) < MAX_ENTRIES)) begin
      src_mem[AW'(clr_cnt_r)] <= '0;
    end else if (cmd.accept && in_data.command == CMD_WR_ENTRY && entry_ok) begin
      src_mem[AW'(in_data.index)] <= in_data.source_neuron;
    end
    if (cmd.ent_step) src_rd_r <= src_mem[AW'(j_r)];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step && (32'(clr_cnt_r) < MAX_NEURONS)) begin
      gfirst_mem[GW'(clr_cnt_r)] <= 8'(clr_cnt_r);
      glen_mem[GW'(clr_cnt_r)]   <= 9'd1;
    end else if (cmd.accept && in_data.command == CMD_WR_GATE && gate_ok) begin
      gfirst_mem[GW'(in_data.index)] <= in_data.first_entry;
      glen_mem[GW'(in_data.index)]   <= in_data.entry_count;
    end
    if (cmd.gate_rd) begin
      gf_rd_r <= gfirst_mem[GW'(g_r)];
      gl_rd_r <= glen_mem[GW'(g_r)];
    end
  end

  assign out_data = out_data_r;

endmodule

[sv/nand_network_update_engine_top.sv]
`timescale 1ns / 1ps
// Write commands (entry, gate, neuron bit) go from the accepted beat through FIN to
// the registered result. Update pass: for each gate inside the vector, GATE reads
// its record, LOAD loads its span and ENT walks one connection entry per step.
// One item at a time; a new beat is taken while the previous result waits.
// After reset a clearing pass of max(MAX_ENTRIES, MAX_NEURONS) addresses loads the
// tables before the first beat is taken; configuration writes are taken throughout.
module nand_network_update_engine_top import nnue_pkg::*; #(
  parameter int MAX_NEURONS = 64,
  parameter int MAX_ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  nnue_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .sts        (sts),
    .cmd        (cmd)
  );

  nnue_dp #(
    .MAX_NEURONS (MAX_NEURONS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

[bench/nand_network_update_engine_top_tb.sv]
`timescale 1ns / 1ps

module nand_network_update_engine_top_tb;
  import nnue_pkg::*;

  localparam int NEURONS    = 64;
  localparam int ENTRIES    = 256;
  localparam int PHASES     = 10;
  localparam int PHASE_ITEMS = 185;
  localparam int LEN_BUDGET = 1024;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_wr_en = 1'b0;
  cfg_idx_t         cfg_index = CFG_SENSOR_COUNT;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // network copy used to work out the expected value vector
  logic [NEURONS-1:0] net_bits;
  logic [5:0]         src_of_entry [ENTRIES];
  logic [7:0]         gate_start   [NEURONS];
  logic [8:0]         gate_len     [NEURONS];
  logic [CFG_W-1:0]   n_sensor, n_deep, n_output;

  in_item_t  cmd_q[$];
  out_item_t values_due_q[$];
  out_item_t due;
  int        planned_len [NEURONS];

  int send_idle_pct = 8;
  int recv_idle_pct = 8;
  int hold_left     = 0;
  bit beat_taken    = 1'b0;

  int n_errors  = 0;
  int n_items   = 0;
  int n_updates = 0;
  int n_bad     = 0;
  int n_results = 0;
  int n_planned = 0;

  nand_network_update_engine_top #(
    .MAX_NEURONS(NEURONS),
    .MAX_ENTRIES(ENTRIES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic out_item_t step_network(in_item_t it);
    out_item_t r;
    int        tgt;
    int        stop;
    logic      drive;
    r.bad_index = 1'b0;
    case (it.command)
      CMD_WR_ENTRY: src_of_entry[it.index] = it.source_neuron;
      CMD_WR_GATE: begin
        if (int'(it.index) < NEURONS) begin
          gate_start[it.index[5:0]] = it.first_entry;
          gate_len[it.index[5:0]]   = it.entry_count;
        end else begin
          r.bad_index = 1'b1;
        end
      end
      CMD_SET_BIT: begin
        if (int'(it.index) < NEURONS) net_bits[it.index[5:0]] = it.bit_value;
        else r.bad_index = 1'b1;
      end
      default: begin
        // walk gates in order, writing in place
        for (int g = 0; g < int'(n_deep) + int'(n_output); g++) begin
          tgt = int'(n_sensor) + g;
          if (g < NEURONS && tgt < NEURONS) begin
            drive = 1'b0;
            stop  = int'(gate_start[g]) + int'(gate_len[g]);
            for (int j = int'(gate_start[g]); j < stop && j < ENTRIES; j++)
              if (!net_bits[src_of_entry[j]]) drive = 1'b1;
            net_bits[tgt] = drive;
          end
        end
      end
    endcase
    r.neuron_values = net_bits;
    return r;
  endfunction

  function automatic in_item_t mk(cmd_code_t c, logic [7:0] idx, logic [5:0] src,
                                  logic [7:0] first, logic [8:0] cnt, logic bv);
    in_item_t it;
    it.command       = c;
    it.index         = idx;
    it.source_neuron = src;
    it.first_entry   = first;
    it.entry_count   = cnt;
    it.bit_value     = bv;
    return it;
  endfunction

  function automatic int planned_total();
    int s;
    s = 0;
    for (int g = 0; g < NEURONS; g++) s += planned_len[g];
    return s;
  endfunction

  task automatic queue_item(in_item_t it);
    if (it.command == CMD_WR_GATE && int'(it.index) < NEURONS)
      planned_len[it.index[5:0]] = int'(it.entry_count);
    cmd_q.push_back(it);
    n_planned++;
  endtask

  task automatic plan_random_item();
    in_item_t it;
    int       roll;
    roll                = $urandom_range(99);
    it.index            = 8'($urandom);
    it.source_neuron    = 6'($urandom);
    it.first_entry      = 8'($urandom);
    it.entry_count      = 9'($urandom);
    it.bit_value        = 1'($urandom);
    if (roll < 28) begin
      it.command = CMD_WR_ENTRY;
    end else if (roll < 46) begin
      it.command = CMD_WR_GATE;
      it.index   = 8'(($urandom_range(99) < 92) ? $urandom_range(NEURONS - 1)
                                                : $urandom_range(255, NEURONS));
      roll = $urandom_range(99);
      if (roll < 85) it.entry_count = 9'($urandom_range(0, 6));
      else if (roll < 97) it.entry_count = 9'($urandom_range(7, 32));
      else it.entry_count = 9'($urandom_range(200, 511));
      // keep the total wiring bounded so update passes stay short
      if (int'(it.index) < NEURONS &&
          planned_total() - planned_len[it.index[5:0]] + int'(it.entry_count) > LEN_BUDGET)
        it.entry_count = 9'($urandom_range(0, 6));
    end else if (roll < 66) begin
      it.command = CMD_SET_BIT;
      it.index   = 8'(($urandom_range(99) < 92) ? $urandom_range(NEURONS - 1)
                                                : $urandom_range(255, NEURONS));
    end else begin
      it.command = CMD_UPDATE;
    end
    queue_item(it);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_SENSOR_COUNT: n_sensor = v;
      CFG_DEEP_COUNT:   n_deep   = v;
      default:          n_output = v;
    endcase
  endtask

  task automatic set_counts(logic [CFG_W-1:0] s, logic [CFG_W-1:0] d, logic [CFG_W-1:0] o);
    write_reg(CFG_SENSOR_COUNT, s);
    write_reg(CFG_DEEP_COUNT, d);
    write_reg(CFG_OUTPUT_COUNT, o);
  endtask

  // wait until every queued beat has returned its result
  task automatic drain();
    do @(negedge clk);
    while (n_results < n_planned);
  endtask

  // accept input beats and predict their results
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      values_due_q.push_back(step_network(in_data));
      if (values_due_q[$].bad_index) n_bad++;
      if (in_data.command == CMD_UPDATE) n_updates++;
      n_items++;
      beat_taken = 1'b1;
    end
  end

  // drive the next beat once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      beat_taken = 1'b0;
      if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= cmd_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure; a long hold counts down here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (values_due_q.size() == 0) begin
        $display("%0t: result beat with nothing due: values %h bad %b",
                 $time, out_data.neuron_values, out_data.bad_index);
        n_errors++;
      end else begin
        due = values_due_q.pop_front();
        if (out_data.neuron_values !== due.neuron_values) begin
          $display("%0t: neuron_values expected %h got %h",
                   $time, due.neuron_values, out_data.neuron_values);
          n_errors++;
        end
        if (out_data.bad_index !== due.bad_index) begin
          $display("%0t: bad_index expected %b got %b",
                   $time, due.bad_index, out_data.bad_index);
          n_errors++;
        end
      end
    end
  end

  initial begin
    net_bits = '0;
    for (int j = 0; j < ENTRIES; j++) src_of_entry[j] = '0;
    for (int g = 0; g < NEURONS; g++) begin
      gate_start[g]  = 8'(g);
      gate_len[g]    = 9'd1;
      planned_len[g] = 1;
    end
    n_sensor = SENSOR_COUNT_RST;
    n_deep   = DEEP_COUNT_RST;
    n_output = OUTPUT_COUNT_RST;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset wiring first, then the corners of every command
    queue_item(mk(CMD_UPDATE, 8'd0, 6'd0, 8'd0, 9'd0, 1'b0));
    queue_item(mk(CMD_SET_BIT, 8'd0, 6'd63, 8'd255, 9'd511, 1'b1));
    queue_item(mk(CMD_UPDATE, 8'd255, 6'd63, 8'd255, 9'd511, 1'b1));
    queue_item(mk(CMD_SET_BIT, 8'd63, 6'd0, 8'd0, 9'd0, 1'b1));
    queue_item(mk(CMD_SET_BIT, 8'd64, 6'd0, 8'd0, 9'd0, 1'b1));
    queue_item(mk(CMD_SET_BIT, 8'd255, 6'd63, 8'd255, 9'd511, 1'b0));
    queue_item(mk(CMD_WR_ENTRY, 8'd0, 6'd63, 8'd0, 9'd0, 1'b0));
    queue_item(mk(CMD_WR_ENTRY, 8'd255, 6'd0, 8'd255, 9'd511, 1'b1));
    queue_item(mk(CMD_WR_ENTRY, 8'd128, 6'd42, 8'd17, 9'd256, 1'b0));
    queue_item(mk(CMD_WR_GATE, 8'd0, 6'd0, 8'd0, 9'd0, 1'b0));
    queue_item(mk(CMD_WR_GATE, 8'd63, 6'd0, 8'd255, 9'd256, 1'b0));
    queue_item(mk(CMD_WR_GATE, 8'd1, 6'd0, 8'd0, 9'd511, 1'b0));
    queue_item(mk(CMD_WR_GATE, 8'd64, 6'd0, 8'd3, 9'd2, 1'b0));
    queue_item(mk(CMD_WR_GATE, 8'd255, 6'd63, 8'd255, 9'd511, 1'b1));
    queue_item(mk(CMD_UPDATE, 8'd0, 6'd0, 8'd0, 9'd0, 1'b0));
    queue_item(mk(CMD_WR_ENTRY, 8'd1, 6'd8, 8'd0, 9'd0, 1'b0));
    queue_item(mk(CMD_UPDATE, 8'd0, 6'd0, 8'd0, 9'd0, 1'b0));
    queue_item(mk(CMD_SET_BIT, 8'd10, 6'd0, 8'd0, 9'd0, 1'b1));
    queue_item(mk(CMD_UPDATE, 8'd0, 6'd0, 8'd0, 9'd0, 1'b0));
    queue_item(mk(CMD_WR_GATE, 8'd1, 6'd0, 8'd1, 9'd1, 1'b0));
    queue_item(mk(CMD_WR_GATE, 8'd63, 6'd0, 8'd63, 9'd1, 1'b0));
    queue_item(mk(CMD_UPDATE, 8'd0, 6'd0, 8'd0, 9'd0, 1'b0));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: set_counts(7'd0, 7'd64, 7'd0);
        2: set_counts(7'd64, 7'd64, 7'd64);
        3: set_counts(7'd127, 7'd127, 7'd127);
        4: set_counts(7'd0, 7'd0, 7'd0);
        5: set_counts(7'd4, 7'd40, 7'd20);
        6: set_counts(7'd16, 7'd32, 7'd16);
        7: set_counts(7'd2, 7'd60, 7'd2);
        8: set_counts(7'($urandom_range(0, 20)), 7'($urandom_range(0, 70)),
                      7'($urandom_range(0, 70)));
        9: set_counts(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                      7'($urandom_range(0, 127)));
        default: ;
      endcase
      // no idling at all on either side for one whole phase
      send_idle_pct = (p == 6) ? 0 : 8;
      recv_idle_pct = (p == 6) ? 0 : 8;
      @(posedge clk);
      if (p == 5) hold_left = 600;
      for (int k = 0; k < PHASE_ITEMS; k++) plan_random_item();
      drain();
    end

    repeat (40) @(posedge clk);
    $display("covered %0d beats: %0d update passes, %0d rejected writes, %0d results",
             n_items, n_updates, n_bad, n_results);
    $display("  over %0d count settings incl. zero, 64 and 127, with a long output hold",
             PHASES);
    if (n_errors == 0 && values_due_q.size() == 0) begin
      $display("nand_network_update_engine_top_tb OK");
    end else begin
      $display("nand_network_update_engine_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #96_000_000;
    $display("timeout with %0d results still due", values_due_q.size());
    $display("nand_network_update_engine_top_tb NOT OK");
    $finish;
  end

endmodule
